### rtl/qlc_pkg.sv
// qlc_pkg: shared constants, types and the CORDIC angle table for the
// quaternion landing classifier. No dependencies.
package qlc_pkg;

   localparam int ANGLE_W  = 16;
   localparam int COUNT_W  = 32;
   localparam int TERM_W   = 34;   // sums of Q1.15 products, scale 2^30
   localparam int CORDIC_W = 40;   // x, y, z inside the rotation chain
   localparam int STEPS    = 32;
   localparam int STEP_IDX_W = $clog2(STEPS);
   localparam int LOW_W    = 15;
   localparam int HIGH_W   = 16;
   localparam int CSR_W    = 16;
   localparam int ROOT_W   = 30;
   localparam int RAD_W    = 59;   // radicand, up to 2^58

   localparam logic [LOW_W-1:0]  SIDE_LOW_RST  = 15'd11469;
   localparam logic [HIGH_W-1:0] SIDE_HIGH_RST = 16'd21299;

   localparam logic [0:0] CSR_SIDE_LOW  = 1'b0;
   localparam logic [0:0] CSR_SIDE_HIGH = 1'b1;

   localparam logic signed [TERM_W-1:0]   UNIT29   = 34'sd536870912;
   localparam logic signed [CORDIC_W-1:0] INT_PI   = 40'sd2147483648;
   localparam logic signed [CORDIC_W-1:0] HALF_PI  = 40'sd1073741824;
   localparam logic signed [CORDIC_W-1:0] ROUND_HALF = 40'sd32768;
   localparam logic [RAD_W-1:0]           RAD_ONE  = 59'(1) << 58;
   localparam logic [COUNT_W-1:0]         COUNT_MAX = '1;

   // atan(2^-i), pi = 2^31
   localparam logic [31:0] ATAN_TAB [STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

   typedef enum logic [1:0] {
      TAG_ROLL  = 2'd0,
      TAG_YAW   = 2'd1,
      TAG_PITCH = 2'd2
   } tag_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'd0,
      ST_MUL   = 3'd1,
      ST_ROLL  = 3'd2,
      ST_YAW   = 3'd3,
      ST_SQRT  = 3'd4,
      ST_PITCH = 3'd5,
      ST_DRAIN = 3'd6,
      ST_DONE  = 3'd7
   } state_type;

   typedef struct packed {
      logic                       valid;
      tag_type                    tag;
      logic                       zero;
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [CORDIC_W-1:0] z;
   } cordic_vec_type;

endpackage

### rtl/qlc_cordic_cell.sv
// qlc_cordic_cell: one vectoring CORDIC micro-rotation, registered.
// Depends on qlc_pkg.
module qlc_cordic_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [qlc_pkg::STEP_IDX_W-1:0]   cell_idx,
   input  qlc_pkg::cordic_vec_type          vec_in,
   output qlc_pkg::cordic_vec_type          vec_out
);

   qlc_pkg::cordic_vec_type step_ff, step_in;
   logic signed [qlc_pkg::CORDIC_W-1:0] xs, ys, ang;

   always_comb begin
      xs  = vec_in.x >>> cell_idx;
      ys  = vec_in.y >>> cell_idx;
      ang = $signed({{(qlc_pkg::CORDIC_W-32){1'b0}}, qlc_pkg::ATAN_TAB[cell_idx]});
      step_in = vec_in;
      if (vec_in.y > 0) begin
         step_in.x = vec_in.x + ys;
         step_in.y = vec_in.y - xs;
         step_in.z = vec_in.z + ang;
      end else begin
         step_in.x = vec_in.x - ys;
         step_in.y = vec_in.y + xs;
         step_in.z = vec_in.z - ang;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

   assign vec_out = step_ff;

endmodule

### rtl/qlc_cordic_chain.sv
// qlc_cordic_chain: quadrant fold plus a row of 32 CORDIC cells.
// Depends on qlc_pkg and qlc_cordic_cell.
module qlc_cordic_chain (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               feed_valid,
   input  qlc_pkg::tag_type                   feed_tag,
   input  logic signed [qlc_pkg::TERM_W-1:0]  feed_x,
   input  logic signed [qlc_pkg::TERM_W-1:0]  feed_y,
   output qlc_pkg::cordic_vec_type            vec_out
);

   qlc_pkg::cordic_vec_type link [qlc_pkg::STEPS+1];
   logic signed [qlc_pkg::CORDIC_W-1:0] ex, ey;

   // left half-plane: rotate by pi first
   always_comb begin
      ex = qlc_pkg::CORDIC_W'(feed_x);
      ey = qlc_pkg::CORDIC_W'(feed_y);
      link[0].valid = feed_valid;
      link[0].tag   = feed_tag;
      link[0].zero  = (feed_x == '0) && (feed_y == '0);
      if (feed_x < 0) begin
         link[0].x = -ex;
         link[0].y = -ey;
         link[0].z = (feed_y >= 0) ? qlc_pkg::INT_PI : -qlc_pkg::INT_PI;
      end else begin
         link[0].x = ex;
         link[0].y = ey;
         link[0].z = '0;
      end
   end

   for (genvar i = 0; i < qlc_pkg::STEPS; i++) begin : g_cell
      qlc_cordic_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (qlc_pkg::STEP_IDX_W'(i)),
         .vec_in   (link[i]),
         .vec_out  (link[i+1])
      );
   end

   assign vec_out = link[qlc_pkg::STEPS];

endmodule

### rtl/qlc_isqrt.sv
// qlc_isqrt: floor square root, two radicand bits per cycle.
// Depends on qlc_pkg.
module qlc_isqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [qlc_pkg::RAD_W-1:0]       radicand,
   output logic                            done,
   output logic [qlc_pkg::ROOT_W-1:0]      root
);

   localparam int R_W = qlc_pkg::RAD_W + 1;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [4:0]            k_ff, k_in;
   logic [qlc_pkg::RAD_W-1:0] n_ff, n_in;
   logic [R_W-1:0]        r_ff, r_in, bit_w, trial;

   always_comb begin
      bit_w   = R_W'(1) << {k_ff, 1'b0};
      trial   = r_ff + bit_w;
      busy_in = busy_ff;
      done_in = 1'b0;
      k_in    = k_ff;
      n_in    = n_ff;
      r_in    = r_ff;
      if (start) begin
         busy_in = 1'b1;
         k_in    = 5'd29;
         n_in    = radicand;
         r_in    = '0;
      end else if (busy_ff) begin
         if (R_W'(n_ff) >= trial) begin
            n_in = n_ff - qlc_pkg::RAD_W'(trial);
            r_in = (r_ff >> 1) + bit_w;
         end else begin
            r_in = r_ff >> 1;
         end
         k_in = k_ff - 5'd1;
         if (k_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      k_ff <= k_in;
      n_ff <= n_in;
      r_ff <= r_in;
   end

   assign done = done_ff;
   assign root = r_ff[qlc_pkg::ROOT_W-1:0];

endmodule

### rtl/quaternion_landing_classifier_unit.sv
// quaternion_landing_classifier_unit: top level, sequencer, classification
// and counters. Depends on qlc_pkg, qlc_cordic_chain and qlc_isqrt.
//
// Usage: one quaternion item (Q1.15 x, y, z, w) enters on req_valid/req_ready.
// The block returns one item on rsp_valid/rsp_ready: roll, pitch and yaw as
// binary angles (pi = 32768), the side/bottom flag and both running counts.
// The products are registered first, then roll and yaw enter the 32-cell
// CORDIC row back to back, the square root starting with yaw; once the root
// is done, pitch enters and drains through the row. One item is in work at
// a time. The result sits in an output register; the next item is accepted
// while it waits, and a stalled receiver only holds the block once the
// following result is finished. Reset loads the band bounds with 11469 and
// 21299, clears both counts and leaves no item pending. Bounds are written
// through csr_we/csr_index/csr_wdata; the user must write them only while
// the block is idle, as the block itself does not enforce this.
module quaternion_landing_classifier_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [15:0]  req_quat_x,
   input  logic signed [15:0]  req_quat_y,
   input  logic signed [15:0]  req_quat_z,
   input  logic signed [15:0]  req_quat_w,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [15:0]  rsp_roll_angle,
   output logic signed [15:0]  rsp_pitch_angle,
   output logic signed [15:0]  rsp_yaw_angle,
   output logic                rsp_on_side,
   output logic [31:0]         rsp_side_total,
   output logic [31:0]         rsp_bottom_total,
   input  logic                csr_we,
   input  logic [0:0]          csr_index,
   input  logic [15:0]         csr_wdata
);

   localparam int TW = qlc_pkg::TERM_W;
   localparam int AW = qlc_pkg::ANGLE_W;

   qlc_pkg::state_type state_ff, state_in;

   logic [qlc_pkg::LOW_W-1:0]  low_ff;
   logic [qlc_pkg::HIGH_W-1:0] high_ff;

   logic signed [15:0] qx_ff, qy_ff, qz_ff, qw_ff;
   logic signed [TW-1:0] roll_y_ff, roll_x_ff, yaw_y_ff, yaw_x_ff, b_ff;
   logic [59:0] bsq_ff;
   logic        sat_ff;

   logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wz, p_xy, p_zz, p_wy, p_zx;

   logic                   feed_valid;
   qlc_pkg::tag_type       feed_tag;
   logic signed [TW-1:0]   feed_x, feed_y;
   qlc_pkg::cordic_vec_type chain_out;

   logic        sqrt_start, sqrt_done;
   logic [qlc_pkg::ROOT_W-1:0] sqrt_root;
   logic [qlc_pkg::RAD_W-1:0]  radicand;

   logic [AW-1:0] roll_ff, yaw_ff, pitch_ff;
   logic          pitch_got_ff;
   logic signed [qlc_pkg::CORDIC_W-1:0] z_round;
   logic [AW-1:0] cap_word;

   logic          out_valid_ff;
   logic [AW-1:0] out_roll_ff, out_pitch_ff, out_yaw_ff;
   logic          out_side_ff;
   logic [qlc_pkg::COUNT_W-1:0] side_cnt_ff, side_cnt_in, bot_cnt_ff, bot_cnt_in;
   logic          load_out, side_hit;
   logic [AW:0]   roll_mag, pitch_mag;

   function automatic logic [AW:0] mag_of(input logic [AW-1:0] a);
      logic [AW:0] m;
      m = a[AW-1] ? ((AW+1)'(~a) + (AW+1)'(1)) & {1'b0, {AW{1'b1}}} : {1'b0, a};
      if (a == {1'b1, {(AW-1){1'b0}}}) begin
         m = {2'b01, {(AW-1){1'b0}}};
      end
      return m;
   endfunction

   // products of the quaternion terms, scale 2^30
   always_comb begin
      p_wx = qw_ff * qx_ff;
      p_yz = qy_ff * qz_ff;
      p_xx = qx_ff * qx_ff;
      p_yy = qy_ff * qy_ff;
      p_wz = qw_ff * qz_ff;
      p_xy = qx_ff * qy_ff;
      p_zz = qz_ff * qz_ff;
      p_wy = qw_ff * qy_ff;
      p_zx = qz_ff * qx_ff;
   end

   assign req_ready = (state_ff == qlc_pkg::ST_IDLE);
   assign load_out  = (state_ff == qlc_pkg::ST_DONE) && (!out_valid_ff || rsp_ready);
   assign radicand  = qlc_pkg::RAD_ONE - bsq_ff[qlc_pkg::RAD_W-1:0];

   always_comb begin
      state_in   = state_ff;
      feed_valid = 1'b0;
      feed_tag   = qlc_pkg::TAG_ROLL;
      feed_x     = roll_x_ff;
      feed_y     = roll_y_ff;
      sqrt_start = 1'b0;
      case (state_ff)
         qlc_pkg::ST_IDLE: begin
            if (req_valid) state_in = qlc_pkg::ST_MUL;
         end
         qlc_pkg::ST_MUL: begin
            state_in = qlc_pkg::ST_ROLL;
         end
         qlc_pkg::ST_ROLL: begin
            feed_valid = 1'b1;
            state_in   = qlc_pkg::ST_YAW;
         end
         qlc_pkg::ST_YAW: begin
            feed_valid = 1'b1;
            feed_tag   = qlc_pkg::TAG_YAW;
            feed_x     = yaw_x_ff;
            feed_y     = yaw_y_ff;
            sqrt_start = 1'b1;
            state_in   = qlc_pkg::ST_SQRT;
         end
         qlc_pkg::ST_SQRT: begin
            if (sqrt_done) state_in = qlc_pkg::ST_PITCH;
         end
         qlc_pkg::ST_PITCH: begin
            feed_valid = 1'b1;
            feed_tag   = qlc_pkg::TAG_PITCH;
            feed_x     = TW'(sqrt_root);
            feed_y     = b_ff;
            state_in   = qlc_pkg::ST_DRAIN;
         end
         qlc_pkg::ST_DRAIN: begin
            if (pitch_got_ff) state_in = qlc_pkg::ST_DONE;
         end
         qlc_pkg::ST_DONE: begin
            if (load_out) state_in = qlc_pkg::ST_IDLE;
         end
         default: state_in = qlc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qlc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= qlc_pkg::SIDE_LOW_RST;
         high_ff <= qlc_pkg::SIDE_HIGH_RST;
      end else if (csr_we) begin
         case (csr_index)
            qlc_pkg::CSR_SIDE_LOW:  low_ff  <= csr_wdata[qlc_pkg::LOW_W-1:0];
            qlc_pkg::CSR_SIDE_HIGH: high_ff <= csr_wdata[qlc_pkg::HIGH_W-1:0];
            default: ;
         endcase
      end
   end

   // operand and term registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         qx_ff <= req_quat_x;
         qy_ff <= req_quat_y;
         qz_ff <= req_quat_z;
         qw_ff <= req_quat_w;
      end
      if (state_ff == qlc_pkg::ST_MUL) begin
         roll_y_ff <= TW'(p_wx) + TW'(p_yz);
         roll_x_ff <= qlc_pkg::UNIT29 - (TW'(p_xx) + TW'(p_yy));
         yaw_y_ff  <= TW'(p_wz) + TW'(p_xy);
         yaw_x_ff  <= qlc_pkg::UNIT29 - (TW'(p_yy) + TW'(p_zz));
         b_ff      <= TW'(p_wy) - TW'(p_zx);
      end
      if (state_ff == qlc_pkg::ST_ROLL) begin
         bsq_ff <= 60'($signed(b_ff[29:0]) * $signed(b_ff[29:0]));
         sat_ff <= (b_ff >= qlc_pkg::UNIT29) || (b_ff <= -qlc_pkg::UNIT29);
      end
   end

   qlc_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (radicand),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   qlc_cordic_chain u_chain (
      .clock      (clock),
      .reset      (reset),
      .feed_valid (feed_valid),
      .feed_tag   (feed_tag),
      .feed_x     (feed_x),
      .feed_y     (feed_y),
      .vec_out    (chain_out)
   );

   // round to the output angle width
   always_comb begin
      z_round  = chain_out.z + qlc_pkg::ROUND_HALF;
      cap_word = chain_out.zero ? '0 : z_round[31:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_got_ff <= 1'b0;
      end else if (state_ff == qlc_pkg::ST_MUL) begin
         pitch_got_ff <= 1'b0;
      end else if (chain_out.valid && chain_out.tag == qlc_pkg::TAG_PITCH) begin
         pitch_got_ff <= 1'b1;
      end
      if (chain_out.valid) begin
         case (chain_out.tag)
            qlc_pkg::TAG_ROLL: roll_ff <= cap_word;
            qlc_pkg::TAG_YAW:  yaw_ff  <= cap_word;
            qlc_pkg::TAG_PITCH: begin
               if (sat_ff) begin
                  pitch_ff <= b_ff[TW-1] ? 16'hC000 : 16'h4000;
               end else begin
                  pitch_ff <= cap_word;
               end
            end
            default: ;
         endcase
      end
   end

   // band test and counters
   always_comb begin
      roll_mag  = mag_of(roll_ff);
      pitch_mag = mag_of(pitch_ff);
      side_hit  = ((roll_mag > (AW+1)'(low_ff)) && (roll_mag < (AW+1)'(high_ff))) ||
                  ((pitch_mag > (AW+1)'(low_ff)) && (pitch_mag < (AW+1)'(high_ff)));
      side_cnt_in = side_cnt_ff;
      bot_cnt_in  = bot_cnt_ff;
      if (side_hit) begin
         if (side_cnt_ff != qlc_pkg::COUNT_MAX) side_cnt_in = side_cnt_ff + 1'b1;
      end else begin
         if (bot_cnt_ff != qlc_pkg::COUNT_MAX) bot_cnt_in = bot_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         side_cnt_ff  <= '0;
         bot_cnt_ff   <= '0;
      end else begin
         if (load_out) begin
            out_valid_ff <= 1'b1;
            side_cnt_ff  <= side_cnt_in;
            bot_cnt_ff   <= bot_cnt_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (load_out) begin
         out_roll_ff  <= roll_ff;
         out_pitch_ff <= pitch_ff;
         out_yaw_ff   <= yaw_ff;
         out_side_ff  <= side_hit;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_roll_angle   = out_roll_ff;
   assign rsp_pitch_angle  = out_pitch_ff;
   assign rsp_yaw_angle    = out_yaw_ff;
   assign rsp_on_side      = out_side_ff;
   assign rsp_side_total   = side_cnt_ff;
   assign rsp_bottom_total = bot_cnt_ff;

endmodule

### rtl/qlc_checker.sv
// qlc_checker: port-level assertions for the landing classifier, bound to
// the top level. Depends on quaternion_landing_classifier_unit ports only.
module qlc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_roll_angle,
   input logic signed [15:0] rsp_pitch_angle,
   input logic               rsp_on_side,
   input logic [31:0]        rsp_side_total,
   input logic [31:0]        rsp_bottom_total
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item taken while one is in work");

   a_count_side: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_on_side) |-> (rsp_side_total != 32'd0))
      else $error("side item with zero side count");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch_angle <= 16'sd16384 && rsp_pitch_angle >= -16'sd16384))
      else $error("pitch beyond a quarter turn");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_roll_angle)))
      else $error("stalled item changed");

endmodule

bind quaternion_landing_classifier_unit qlc_checker u_qlc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_roll_angle   (rsp_roll_angle),
   .rsp_pitch_angle  (rsp_pitch_angle),
   .rsp_on_side      (rsp_on_side),
   .rsp_side_total   (rsp_side_total),
   .rsp_bottom_total (rsp_bottom_total)
);

### bench/tb.sv
// Testbench for quaternion_landing_classifier_unit: scoreboard class with an
// integer CORDIC predictor, bursty sender, stalling receiver, bound writes.
// Depends on qlc_pkg and the RTL of the unit.
`timescale 1ns / 1ps

typedef struct {
   logic signed [15:0] x, y, z, w;
} quat_item_type;

typedef struct {
   logic [15:0] roll, pitch, yaw;
   logic        side;
   logic [31:0] side_total, bottom_total;
} landing_item_type;

class landing_scoreboard;
   landing_item_type expected_q[$];
   logic [14:0]     band_low  = qlc_pkg::SIDE_LOW_RST;
   logic [15:0]     band_high = qlc_pkg::SIDE_HIGH_RST;
   longint unsigned side_count, bottom_count;
   int              mismatches;

   // atan2 in vectoring mode, pi = 2^31
   function longint vector_angle(longint yv, longint xv);
      longint acc, xs, ys;
      acc = 0;
      if (xv == 0 && yv == 0) return 0;
      if (xv < 0) begin
         acc = (yv >= 0) ? 64'sd2147483648 : -64'sd2147483648;
         xv = -xv;
         yv = -yv;
      end
      for (int i = 0; i < 32; i++) begin
         xs = xv >>> i;
         ys = yv >>> i;
         if (yv > 0) begin
            xv += ys; yv -= xs; acc += longint'(qlc_pkg::ATAN_TAB[i]);
         end else begin
            xv -= ys; yv += xs; acc -= longint'(qlc_pkg::ATAN_TAB[i]);
         end
      end
      return acc;
   endfunction

   function bit [63:0] root_floor(bit [63:0] n);
      bit [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function logic [15:0] to_binary_angle(longint a);
      longint t;
      t = (a + 32768) >>> 16;
      return t[15:0];
   endfunction

   function bit in_side_band(logic [15:0] a);
      int unsigned m;
      m = a[15] ? 32'd65536 - a : a;
      return m > band_low && m < band_high;
   endfunction

   function void set_bound(logic idx, logic [15:0] v);
      if (idx == qlc_pkg::CSR_SIDE_LOW) band_low = v[14:0];
      else band_high = v;
   endfunction

   function void note_input(quat_item_type q);
      longint x, y, z, w, b, pz;
      landing_item_type e;
      x = q.x; y = q.y; z = q.z; w = q.w;
      e.roll = to_binary_angle(vector_angle(w * x + y * z, 64'sd536870912 - (x * x + y * y)));
      e.yaw  = to_binary_angle(vector_angle(w * z + x * y, 64'sd536870912 - (y * y + z * z)));
      b = w * y - z * x;
      if (b >= 64'sd536870912) pz = 64'sd1073741824;
      else if (b <= -64'sd536870912) pz = -64'sd1073741824;
      else pz = vector_angle(b, longint'(root_floor((64'd1 << 58) - 64'(b * b))));
      e.pitch = to_binary_angle(pz);
      e.side = in_side_band(e.roll) || in_side_band(e.pitch);
      if (e.side) begin
         if (side_count < 64'hFFFF_FFFF) side_count++;
      end else begin
         if (bottom_count < 64'hFFFF_FFFF) bottom_count++;
      end
      e.side_total = side_count[31:0];
      e.bottom_total = bottom_count[31:0];
      expected_q.push_back(e);
   endfunction

   task report(string what, logic [31:0] got, logic [31:0] want);
      $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   task check_result(landing_item_type r);
      landing_item_type e;
      if (expected_q.size() == 0) begin
         report("unexpected result item", 32'd0, 32'd0);
         return;
      end
      e = expected_q.pop_front();
      if (r.roll !== e.roll) report("roll_angle", 32'(r.roll), 32'(e.roll));
      if (r.pitch !== e.pitch) report("pitch_angle", 32'(r.pitch), 32'(e.pitch));
      if (r.yaw !== e.yaw) report("yaw_angle", 32'(r.yaw), 32'(e.yaw));
      if (r.side !== e.side) report("on_side", 32'(r.side), 32'(e.side));
      if (r.side_total !== e.side_total) report("side_total", r.side_total, e.side_total);
      if (r.bottom_total !== e.bottom_total)
         report("bottom_total", r.bottom_total, e.bottom_total);
   endtask
endclass

module tb;

   localparam int STALL_LIMIT = 5000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [15:0] req_quat_x = '0, req_quat_y = '0, req_quat_z = '0, req_quat_w = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_roll_angle, rsp_pitch_angle, rsp_yaw_angle;
   logic               rsp_on_side;
   logic [31:0]        rsp_side_total, rsp_bottom_total;
   logic               csr_we = 1'b0;
   logic [0:0]         csr_index = '0;
   logic [15:0]        csr_wdata = '0;

   landing_scoreboard sb = new();
   int  idle_cycles = 0;
   int  hold_off = 0;
   int  burst_left = 0;
   bit  no_gaps = 0;

   quaternion_landing_classifier_unit u_dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_input('{req_quat_x, req_quat_y, req_quat_z, req_quat_w});
         if (rsp_valid && rsp_ready)
            sb.check_result('{rsp_roll_angle, rsp_pitch_angle, rsp_yaw_angle, rsp_on_side,
                              rsp_side_total, rsp_bottom_total});
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // receiver: stall pattern drawn at random from four modes; long hold-offs on request
   initial begin
      int mode, span;
      mode = 0;
      span = 0;
      forever begin
         @(negedge clock);
         if (span == 0) begin
            mode = $urandom_range(0, 3);
            span = 150;
         end
         span--;
         if (hold_off > 0) begin
            hold_off--;
            rsp_ready = 1'b0;
         end else case (mode)
            0: rsp_ready = 1'b1;
            1: rsp_ready = 1'($urandom_range(0, 1));
            2: rsp_ready = ($urandom_range(0, 7) != 0);
            default: rsp_ready = ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   task send_item(quat_item_type q);
      if (!no_gaps && burst_left == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 150)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left > 0) burst_left--;
      req_valid = 1'b1;
      {req_quat_x, req_quat_y, req_quat_z, req_quat_w} = {q.x, q.y, q.z, q.w};
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
   endtask

   task drain_and_write(logic [15:0] lo, logic [15:0] hi);
      req_valid = 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
      csr_we = 1'b1; csr_index = qlc_pkg::CSR_SIDE_LOW; csr_wdata = lo;
      sb.set_bound(qlc_pkg::CSR_SIDE_LOW, lo);
      @(negedge clock);
      csr_index = qlc_pkg::CSR_SIDE_HIGH; csr_wdata = hi;
      sb.set_bound(qlc_pkg::CSR_SIDE_HIGH, hi);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function logic signed [15:0] edge_value();
      case ($urandom_range(0, 4))
         0: return -16'sd32768;
         1: return 16'sd32767;
         2: return 16'sd0;
         3: return -16'sd1;
         default: return 16'($urandom);
      endcase
   endfunction

   function quat_item_type random_quat();
      quat_item_type q;
      real c[4], norm;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         q = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
      end else if (pick < 30) begin
         q = '{edge_value(), edge_value(), edge_value(), edge_value()};
      end else if (pick < 40) begin
         // near the pitch saturation edge
         q.w = 16'(23170 + $urandom_range(0, 2) - 1);
         q.y = 16'(($urandom_range(0, 1) ? 1 : -1) * (23170 + $urandom_range(0, 2) - 1));
         q.x = 16'($urandom_range(0, 4) - 2);
         q.z = 16'($urandom_range(0, 4) - 2);
      end else begin
         norm = 0.0;
         foreach (c[i]) begin
            c[i] = ($urandom_range(0, 3) == 0) ? 0.0 : real'($urandom_range(0, 65535)) - 32768.0;
            norm += c[i] * c[i];
         end
         if (norm == 0.0) begin
            c[3] = 1.0;
            norm = 1.0;
         end
         norm = $sqrt(norm);
         q.x = 16'($rtoi(c[0] / norm * 32767.0));
         q.y = 16'($rtoi(c[1] / norm * 32767.0));
         q.z = 16'($rtoi(c[2] / norm * 32767.0));
         q.w = 16'($rtoi(c[3] / norm * 32767.0));
      end
      return q;
   endfunction

   initial begin
      quat_item_type directed[$];
      logic [15:0] lo, hi;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      directed = '{
         '{16'sd0, 16'sd0, 16'sd0, 16'sd0},
         '{16'sd0, 16'sd0, 16'sd0, 16'sd32767},
         '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768},
         '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767},
         '{16'sd32767, 16'sd0, 16'sd0, 16'sd0},
         '{16'sd0, 16'sd32767, 16'sd0, 16'sd0},
         '{16'sd0, 16'sd0, 16'sd32767, 16'sd0},
         '{-16'sd32768, 16'sd0, 16'sd0, 16'sd0},
         '{16'sd23170, 16'sd0, 16'sd0, 16'sd23170},
         '{-16'sd23170, 16'sd0, 16'sd0, 16'sd23170},
         '{16'sd0, 16'sd23170, 16'sd0, 16'sd23170},
         '{16'sd0, 16'sd23171, 16'sd0, 16'sd23171},
         '{16'sd0, -16'sd23171, 16'sd0, 16'sd23171},
         '{16'sd23171, 16'sd0, 16'sd23171, 16'sd0},
         '{16'sd0, 16'sd0, 16'sd23170, 16'sd23170},
         '{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768},
         '{16'sd1, -16'sd1, 16'sd1, -16'sd1},
         '{16'sd12540, 16'sd0, 16'sd0, 16'sd30274},
         '{16'sd0, 16'sd12540, 16'sd0, 16'sd30274},
         '{-16'sd30274, 16'sd0, 16'sd0, 16'sd12540}
      };
      no_gaps = 1;
      foreach (directed[i]) send_item(directed[i]);
      no_gaps = 0;

      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: begin lo = 16'd0;     hi = 16'd32768; end
            1: begin lo = 16'd32767; hi = 16'd0;     end
            2: begin lo = 16'd16383; hi = 16'd16385; end
            3: begin lo = 16'd11469; hi = 16'd21299; end
            4: begin lo = 16'hFFFF;  hi = 16'hFFFF;  end
            5: begin lo = 16'd100;   hi = 16'd101;   end
            default: begin
               lo = 16'($urandom_range(0, 16384));
               hi = 16'(lo + $urandom_range(0, 16384));
            end
         endcase
         drain_and_write(lo, hi);
         no_gaps = (phase == 3);
         for (int n = 0; n < 255; n++) begin
            // long receiver hold-off while items keep coming
            if (phase == 1 && n == 20) hold_off = 600;
            send_item(random_quat());
         end
      end

      req_valid = 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (sb.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule

### sim.f
rtl/qlc_pkg.sv
rtl/qlc_cordic_cell.sv
rtl/qlc_cordic_chain.sv
rtl/qlc_isqrt.sv
rtl/quaternion_landing_classifier_unit.sv
rtl/qlc_checker.sv
bench/tb.sv
